// ===== rtl/svs_pkg.sv =====
// shared widths, codes and controller/datapath handshake types for the seam vertex splitter
`timescale 1ns / 1ps

package svs_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned VERT_W = 11;
  localparam int unsigned IDX_W  = 12;
  localparam int unsigned CNT_W  = 12;
  localparam int unsigned MIN_W  = 16;
  localparam int unsigned CLS_W  = 2;

  localparam int unsigned MAX_VERTS_DEFAULT = 2048;

  // input operations
  localparam logic [OP_W-1:0] OP_CLASSIFY = 2'd0;
  localparam logic [OP_W-1:0] OP_REMAP    = 2'd1;
  localparam logic [OP_W-1:0] OP_START    = 2'd2;

  // per-vertex side classes
  localparam logic [CLS_W-1:0] CLS_FRONT  = 2'd0;
  localparam logic [CLS_W-1:0] CLS_BACK   = 2'd1;
  localparam logic [CLS_W-1:0] CLS_DUP    = 2'd2;
  localparam logic [CLS_W-1:0] CLS_UNSEEN = 2'd3;

  // result kinds
  localparam logic KIND_COLLISION = 1'b0;
  localparam logic KIND_REMAP     = 1'b1;

  localparam logic [MIN_W-1:0] MIN_RESET    = 16'hFFFF;
  localparam logic [CNT_W-1:0] VCOUNT_RESET = 12'd1;

  typedef struct packed {
    logic accept;    // take the input word and read both stores
    logic commit;    // apply the held word to state and output register
    logic clr_step;  // write one class entry back to unseen
  } svs_cmd_t;

  typedef struct packed {
    logic has_result;
    logic is_start;
    logic out_stall;
    logic clr_last;
  } svs_sts_t;

endpackage

// ===== rtl/svs_if.sv =====
// valid/ready channel interfaces for input words, result words and the config write
`timescale 1ns / 1ps

interface svs_in_if;
  logic                       valid;
  logic                       ready;
  logic [svs_pkg::OP_W-1:0]   op;
  logic [svs_pkg::VERT_W-1:0] vertex;
  logic                       front_facing;
  logic                       on_seam;

  modport source (output valid, output op, output vertex, output front_facing,
                  output on_seam, input ready);
  modport sink   (input valid, input op, input vertex, input front_facing,
                  input on_seam, output ready);
endinterface

interface svs_out_if;
  logic                       valid;
  logic                       ready;
  logic                       kind;
  logic [svs_pkg::IDX_W-1:0]  vertex_index;
  logic [svs_pkg::VERT_W-1:0] original_vertex;
  logic [svs_pkg::CNT_W-1:0]  collision_count;
  logic [svs_pkg::MIN_W-1:0]  index_min;
  logic [svs_pkg::IDX_W-1:0]  index_max;

  modport source (output valid, output kind, output vertex_index, output original_vertex,
                  output collision_count, output index_min, output index_max,
                  input ready);
  modport sink   (input valid, input kind, input vertex_index, input original_vertex,
                  input collision_count, input index_min, input index_max,
                  output ready);
endinterface

interface svs_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [svs_pkg::CNT_W-1:0] vertex_count;

  modport source (output valid, output vertex_count, input ready);
  modport sink   (input valid, input vertex_count, output ready);
endinterface

// ===== rtl/svs_datapath.sv =====
// datapath: class and duplicate stores, counters, running min/max and output register
`timescale 1ns / 1ps

module svs_datapath #(
  parameter int unsigned MAX_VERTS = svs_pkg::MAX_VERTS_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [svs_pkg::OP_W-1:0]    op_i,
  input  logic [svs_pkg::VERT_W-1:0]  vertex_i,
  input  logic                        front_facing_i,
  input  logic                        on_seam_i,
  input  logic                        cfg_valid_i,
  input  logic [svs_pkg::CNT_W-1:0]   cfg_vertex_count_i,
  input  svs_pkg::svs_cmd_t           cmd_i,
  output svs_pkg::svs_sts_t           sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic                        out_kind_o,
  output logic [svs_pkg::IDX_W-1:0]   out_vertex_index_o,
  output logic [svs_pkg::VERT_W-1:0]  out_original_vertex_o,
  output logic [svs_pkg::CNT_W-1:0]   out_collision_count_o,
  output logic [svs_pkg::MIN_W-1:0]   out_index_min_o,
  output logic [svs_pkg::IDX_W-1:0]   out_index_max_o
);

  localparam int unsigned AW = $clog2(MAX_VERTS);

  // stores
  logic [svs_pkg::CLS_W-1:0] class_mem [MAX_VERTS];
  logic [svs_pkg::IDX_W-1:0] dup_mem   [MAX_VERTS];

  // held word and registered read data
  logic [svs_pkg::OP_W-1:0]   op_q;
  logic [svs_pkg::VERT_W-1:0] vert_q;
  logic                       bs_q;
  logic [svs_pkg::CLS_W-1:0]  cls_rd_q;
  logic [svs_pkg::IDX_W-1:0]  dup_rd_q;

  // state registers
  logic [svs_pkg::CNT_W-1:0] vcount_q;
  logic [svs_pkg::CNT_W-1:0] coll_q, coll_d;
  logic [svs_pkg::MIN_W-1:0] min_q, min_d;
  logic [svs_pkg::IDX_W-1:0] max_q, max_d;
  logic [AW-1:0]             clr_q, clr_d;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic                       out_kind_q;
  logic [svs_pkg::IDX_W-1:0]  out_idx_q;
  logic [svs_pkg::VERT_W-1:0] out_vert_q;
  logic [svs_pkg::CNT_W-1:0]  out_coll_q;
  logic [svs_pkg::MIN_W-1:0]  out_min_q;
  logic [svs_pkg::IDX_W-1:0]  out_max_q;

  logic [AW-1:0]             rd_addr, item_addr, cls_wa;
  logic [svs_pkg::CLS_W-1:0] cls_wd;
  logic                      cls_we, dup_we;
  logic                      is_classify, is_remap, is_start;
  logic                      unseen, conflict, has_result;
  logic [svs_pkg::IDX_W-1:0] dup_new, fin;
  logic                      clr_last, load_out;

  assign rd_addr   = AW'(vertex_i);
  assign item_addr = AW'(vert_q);

  assign is_classify = (op_q == svs_pkg::OP_CLASSIFY);
  assign is_remap    = (op_q == svs_pkg::OP_REMAP);
  assign is_start    = (op_q == svs_pkg::OP_START);

  assign unseen   = (cls_rd_q == svs_pkg::CLS_UNSEEN);
  // class already seen and differs from what this corner says, and vertex not split yet
  assign conflict = is_classify && !unseen && (cls_rd_q != svs_pkg::CLS_DUP) &&
                    (cls_rd_q != {1'b0, bs_q});
  assign has_result = conflict || is_remap;

  assign dup_new = vcount_q + coll_q;
  assign fin = (bs_q && (cls_rd_q != svs_pkg::CLS_BACK)) ? dup_rd_q
                                                         : svs_pkg::IDX_W'(vert_q);

  assign clr_last = (clr_q == AW'(MAX_VERTS - 1));
  assign load_out = cmd_i.commit && has_result;

  always_comb begin
    cls_we = 1'b0;
    cls_wa = item_addr;
    cls_wd = svs_pkg::CLS_UNSEEN;
    dup_we = 1'b0;
    if (cmd_i.clr_step) begin
      cls_we = 1'b1;
      cls_wa = clr_q;
    end else if (cmd_i.commit && is_classify && unseen) begin
      cls_we = 1'b1;
      cls_wd = {1'b0, bs_q};
    end else if (cmd_i.commit && conflict) begin
      cls_we = 1'b1;
      cls_wd = svs_pkg::CLS_DUP;
      dup_we = 1'b1;
    end
  end

  always_comb begin
    coll_d = coll_q;
    min_d  = min_q;
    max_d  = max_q;
    if (cmd_i.commit) begin
      if (is_start) begin
        coll_d = '0;
        min_d  = svs_pkg::MIN_RESET;
        max_d  = '0;
      end else if (conflict) begin
        coll_d = coll_q + 1'b1;
      end else if (is_remap) begin
        if (svs_pkg::MIN_W'(fin) < min_q) begin
          min_d = svs_pkg::MIN_W'(fin);
        end
        if (fin > max_q) begin
          max_d = fin;
        end
      end
    end
  end

  always_comb begin
    clr_d = clr_q;
    if (cmd_i.clr_step) begin
      clr_d = clr_last ? '0 : clr_q + 1'b1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cls_we) begin
      class_mem[cls_wa] <= cls_wd;
    end
    if (dup_we) begin
      dup_mem[item_addr] <= dup_new;
    end
    if (cmd_i.accept) begin
      cls_rd_q <= class_mem[rd_addr];
      dup_rd_q <= dup_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_i;
      vert_q <= vertex_i;
      bs_q   <= !front_facing_i && on_seam_i;
    end
    if (load_out) begin
      out_kind_q <= is_remap ? svs_pkg::KIND_REMAP : svs_pkg::KIND_COLLISION;
      out_idx_q  <= is_remap ? fin : dup_new;
      out_vert_q <= vert_q;
      out_coll_q <= coll_d;
      out_min_q  <= min_d;
      out_max_q  <= max_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q    <= svs_pkg::VCOUNT_RESET;
      coll_q      <= '0;
      min_q       <= svs_pkg::MIN_RESET;
      max_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        vcount_q <= cfg_vertex_count_i;
      end
      coll_q      <= coll_d;
      min_q       <= min_d;
      max_q       <= max_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign sts_o.has_result = has_result;
  assign sts_o.is_start   = is_start;
  assign sts_o.out_stall  = out_valid_q && !out_ready_i;
  assign sts_o.clr_last   = clr_last;

  assign out_valid_o           = out_valid_q;
  assign out_kind_o            = out_kind_q;
  assign out_vertex_index_o    = out_idx_q;
  assign out_original_vertex_o = out_vert_q;
  assign out_collision_count_o = out_coll_q;
  assign out_index_min_o       = out_min_q;
  assign out_index_max_o       = out_max_q;

  a_out_rise_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.commit))
    else $error("result word appeared without a commit");

  a_coll_only_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> $stable(coll_q))
    else $error("collision count moved without a commit");

  a_max_not_below_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (min_q != svs_pkg::MIN_RESET) |-> (svs_pkg::MIN_W'(max_q) >= min_q))
    else $error("running max below running min");

endmodule

// ===== rtl/svs_ctrl.sv =====
// controller: sequences accept, execute and the class store clearing sweep
`timescale 1ns / 1ps

module svs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  svs_pkg::svs_sts_t sts_i,
  output svs_pkg::svs_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
  // hold the word while a waiting result still blocks the output register
  assign cmd_o.commit   = (state_q == ST_EXEC) && !(sts_i.has_result && sts_i.out_stall);
  assign cmd_o.clr_step = (state_q == ST_CLEAR);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_o.commit) begin
          state_d = sts_i.is_start ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // reset starts with a clearing sweep of the class store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> (state_q == ST_EXEC))
    else $error("accepted word not executed next cycle");

  a_sweep_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) && sts_i.clr_last |=> (state_q == ST_IDLE))
    else $error("clearing sweep did not return to idle");

endmodule

// ===== rtl/seam_vertex_splitter_top.sv =====
// the input word and both store reads are registered on accept; the result word is loaded on commit
// input: one corner at a time, set by the registered read of the class store
//   followed by its write-back; a waiting unaccepted result stalls only a word with a result
// start op: a clearing sweep over all MAX_VERTS class store entries, no input taken
// reset: async active low, then a clearing sweep over all MAX_VERTS class store entries before the first word
// top level of the seam vertex splitter
`timescale 1ns / 1ps

module seam_vertex_splitter_top #(
  parameter int unsigned MAX_VERTS = svs_pkg::MAX_VERTS_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  svs_in_if.sink    in_i,
  svs_out_if.source out_o,
  svs_cfg_if.sink   cfg_i
);

  svs_pkg::svs_cmd_t cmd;
  svs_pkg::svs_sts_t sts;
  logic              in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;

  svs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  svs_datapath #(
    .MAX_VERTS (MAX_VERTS)
  ) u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .op_i                  (in_i.op),
    .vertex_i              (in_i.vertex),
    .front_facing_i        (in_i.front_facing),
    .on_seam_i             (in_i.on_seam),
    .cfg_valid_i           (cfg_i.valid),
    .cfg_vertex_count_i    (cfg_i.vertex_count),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .out_ready_i           (out_o.ready),
    .out_valid_o           (out_o.valid),
    .out_kind_o            (out_o.kind),
    .out_vertex_index_o    (out_o.vertex_index),
    .out_original_vertex_o (out_o.original_vertex),
    .out_collision_count_o (out_o.collision_count),
    .out_index_min_o       (out_o.index_min),
    .out_index_max_o       (out_o.index_max)
  );

endmodule
